### src/rmtea_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rmtea_pkg;

    localparam int ELEMENT_FRAC_BITS_DEF = 16;
    localparam int ANGLE_FRAC_BITS_DEF   = 8;

    localparam int NORM_W       = 32;
    localparam int PRE_SCALE    = 8;
    localparam int ZFRAC        = 16;
    localparam int CW           = 44;
    localparam int ZW           = 27;
    localparam int SQ_W         = 64;
    localparam int SQRT_STEPS   = 32;
    localparam int CORDIC_STEPS = 23;
    localparam int LANES        = 4;

    localparam int LANE_B  = 0;
    localparam int LANE_A  = 1;
    localparam int LANE_C  = 2;
    localparam int LANE_CS = 3;

    localparam logic signed [ZW-1:0] DEG90    = ZW'(90 * 65536);
    localparam logic signed [ZW-1:0] DEG180   = ZW'(180 * 65536);
    localparam logic signed [ZW:0]   SING_TOL = (ZW+1)'(3754);

    typedef enum logic [1:0] {
        CASE_NORMAL = 2'd0,
        CASE_POS    = 2'd1,
        CASE_NEG    = 2'd2
    } t_case;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_lane;

    typedef t_lane [LANES-1:0] t_lane_vec;

    function automatic logic signed [ZW-1:0] atan_t(input int unsigned i);
        case (i)
            0:       return ZW'(2949120);
            1:       return ZW'(1740967);
            2:       return ZW'(919879);
            3:       return ZW'(466945);
            4:       return ZW'(234379);
            5:       return ZW'(117304);
            6:       return ZW'(58666);
            7:       return ZW'(29335);
            8:       return ZW'(14668);
            9:       return ZW'(7334);
            10:      return ZW'(3667);
            11:      return ZW'(1833);
            12:      return ZW'(917);
            13:      return ZW'(458);
            14:      return ZW'(229);
            15:      return ZW'(115);
            16:      return ZW'(57);
            17:      return ZW'(29);
            18:      return ZW'(14);
            19:      return ZW'(7);
            20:      return ZW'(4);
            21:      return ZW'(2);
            22:      return ZW'(1);
            default: return '0;
        endcase
    endfunction

    function automatic t_lane prerot(input logic signed [CW-1:0] y,
                                     input logic signed [CW-1:0] x);
        t_lane l;
        l.x = x;
        l.y = y;
        l.z = '0;
        if (x[CW-1]) begin
            l.z = y[CW-1] ? -DEG180 : DEG180;
            l.x = -x;
            l.y = -y;
        end
        return l;
    endfunction

endpackage

`default_nettype wire

### src/rmtea_sqrt_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module rmtea_sqrt_stage #(
    parameter int STEP   = 0,
    parameter int SIDE_W = 126
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire logic                           i_valid,
    input  wire logic [rmtea_pkg::SQ_W-1:0]     i_n,
    input  wire logic [rmtea_pkg::SQ_W-1:0]     i_r,
    input  wire logic [SIDE_W-1:0]              i_side,
    output logic                                o_valid,
    output logic [rmtea_pkg::SQ_W-1:0]          o_n,
    output logic [rmtea_pkg::SQ_W-1:0]          o_r,
    output logic [SIDE_W-1:0]                   o_side
);
    import rmtea_pkg::*;

    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * STEP);

    logic [SQ_W-1:0] w_t;
    logic [SQ_W-1:0] n_n;
    logic [SQ_W-1:0] n_r;
    logic            r_valid;
    logic [SQ_W-1:0] r_n;
    logic [SQ_W-1:0] r_r;
    logic [SIDE_W-1:0] r_side;

    always_comb begin
        w_t = i_r + BIT;
        if (i_n >= w_t) begin
            n_n = i_n - w_t;
            n_r = (i_r >> 1) + BIT;
        end else begin
            n_n = i_n;
            n_r = i_r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n    <= n_n;
            r_r    <= n_r;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_n     = r_n;
    assign o_r     = r_r;
    assign o_side  = r_side;

endmodule

`default_nettype wire

### src/rmtea_cordic_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module rmtea_cordic_stage #(
    parameter int STEP = 0
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire rmtea_pkg::t_lane_vec  i_lanes,
    output logic                       o_valid,
    output rmtea_pkg::t_lane_vec       o_lanes
);
    import rmtea_pkg::*;

    localparam logic signed [ZW-1:0] ANG = atan_t(STEP);

    t_lane_vec n_lanes;
    t_lane_vec r_lanes;
    logic      r_valid;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            if (!i_lanes[k].y[CW-1]) begin
                n_lanes[k].x = i_lanes[k].x + (i_lanes[k].y >>> STEP);
                n_lanes[k].y = i_lanes[k].y - (i_lanes[k].x >>> STEP);
                n_lanes[k].z = i_lanes[k].z + ANG;
            end else begin
                n_lanes[k].x = i_lanes[k].x - (i_lanes[k].y >>> STEP);
                n_lanes[k].y = i_lanes[k].y + (i_lanes[k].x >>> STEP);
                n_lanes[k].z = i_lanes[k].z - ANG;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lanes <= n_lanes;
        end
    end

    assign o_valid = r_valid;
    assign o_lanes = r_lanes;

endmodule

`default_nettype wire

### src/rmtea_out.sv
`timescale 1ns / 1ps
`default_nettype none

module rmtea_out #(
    parameter int ANGLE_FRAC_BITS = rmtea_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire rmtea_pkg::t_lane_vec        i_lanes,
    output logic                             o_valid,
    output logic [ANGLE_FRAC_BITS+8:0]       o_angle_a,
    output logic [ANGLE_FRAC_BITS+7:0]       o_angle_b,
    output logic [ANGLE_FRAC_BITS+8:0]       o_angle_c,
    output logic [1:0]                       o_case_code
);
    import rmtea_pkg::*;

    localparam int AC_W = ANGLE_FRAC_BITS + 9;
    localparam int B_W  = ANGLE_FRAC_BITS + 8;
    localparam int RS   = ZFRAC - ANGLE_FRAC_BITS;
    localparam logic [ZW-1:0] HALF   = (ZW'(1) << RS) >> 1;
    localparam logic [ZW-1:0] LIM_AC = ZW'(180) << ANGLE_FRAC_BITS;
    localparam logic [ZW-1:0] LIM_B  = ZW'(90) << ANGLE_FRAC_BITS;

    logic signed [ZW:0]   w_dp;
    logic signed [ZW:0]   w_dm;
    logic signed [ZW-1:0] w_a;
    logic signed [ZW-1:0] w_b;
    logic signed [ZW-1:0] w_c;
    t_case                w_code;

    logic        r_x_valid;
    logic [ZW-1:0] r_a_mag, r_b_mag, r_c_mag;
    logic        r_a_neg, r_b_neg, r_c_neg;
    t_case       r_x_code;

    logic [ZW-1:0] w_qa, w_qb, w_qc;
    logic [ZW-1:0] w_sa, w_sb, w_sc;
    logic [ZW-1:0] n_a, n_b, n_c;

    logic          r_valid;
    logic [AC_W-1:0] r_angle_a;
    logic [B_W-1:0]  r_angle_b;
    logic [AC_W-1:0] r_angle_c;
    t_case           r_code;

    always_comb begin
        w_b  = i_lanes[LANE_B].z;
        w_dp = (ZW+1)'(w_b) - (ZW+1)'(DEG90);
        w_dm = (ZW+1)'(w_b) + (ZW+1)'(DEG90);
        if (w_dp <= SING_TOL && w_dp >= -SING_TOL) begin
            w_code = CASE_POS;
            w_a    = '0;
            w_c    = i_lanes[LANE_CS].z;
        end else if (w_dm <= SING_TOL && w_dm >= -SING_TOL) begin
            w_code = CASE_NEG;
            w_a    = '0;
            w_c    = -i_lanes[LANE_CS].z;
        end else begin
            w_code = CASE_NORMAL;
            w_a    = i_lanes[LANE_A].z;
            w_c    = i_lanes[LANE_C].z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_valid <= 1'b0;
            r_valid   <= 1'b0;
        end else if (i_en) begin
            r_x_valid <= i_valid;
            r_valid   <= r_x_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_neg  <= w_a[ZW-1];
            r_b_neg  <= w_b[ZW-1];
            r_c_neg  <= w_c[ZW-1];
            r_a_mag  <= w_a[ZW-1] ? ZW'(-w_a) : ZW'(w_a);
            r_b_mag  <= w_b[ZW-1] ? ZW'(-w_b) : ZW'(w_b);
            r_c_mag  <= w_c[ZW-1] ? ZW'(-w_c) : ZW'(w_c);
            r_x_code <= w_code;
        end
    end

    always_comb begin
        w_qa = (r_a_mag + HALF) >> RS;
        w_qb = (r_b_mag + HALF) >> RS;
        w_qc = (r_c_mag + HALF) >> RS;
        w_sa = (w_qa > LIM_AC) ? LIM_AC : w_qa;
        w_sb = (w_qb > LIM_B) ? LIM_B : w_qb;
        w_sc = (w_qc > LIM_AC) ? LIM_AC : w_qc;
        n_a  = r_a_neg ? -w_sa : w_sa;
        n_b  = r_b_neg ? -w_sb : w_sb;
        n_c  = r_c_neg ? -w_sc : w_sc;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle_a <= n_a[AC_W-1:0];
            r_angle_b <= n_b[B_W-1:0];
            r_angle_c <= n_c[AC_W-1:0];
            r_code    <= r_x_code;
        end
    end

    assign o_valid     = r_valid;
    assign o_angle_a   = r_angle_a;
    assign o_angle_b   = r_angle_b;
    assign o_angle_c   = r_angle_c;
    assign o_case_code = r_code;

endmodule

`default_nettype wire

### src/rotation_matrix_to_euler_angles_top.sv
// Throughput: one matrix per cycle; the 32-step square root pipe and the
// 23-step CORDIC pipe each take one step per stage.
// The whole pipe holds while an output beat waits to be taken.
// Reset (synchronous, active low) clears every stage valid bit.
`timescale 1ns / 1ps
`default_nettype none

module rotation_matrix_to_euler_angles_top #(
    parameter int ELEMENT_FRAC_BITS = rmtea_pkg::ELEMENT_FRAC_BITS_DEF,
    parameter int ANGLE_FRAC_BITS   = rmtea_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic signed [ELEMENT_FRAC_BITS+1:0] i_r00,
    input  wire logic signed [ELEMENT_FRAC_BITS+1:0] i_r10,
    input  wire logic signed [ELEMENT_FRAC_BITS+1:0] i_r20,
    input  wire logic signed [ELEMENT_FRAC_BITS+1:0] i_r01,
    input  wire logic signed [ELEMENT_FRAC_BITS+1:0] i_r11,
    input  wire logic signed [ELEMENT_FRAC_BITS+1:0] i_r21,
    input  wire logic signed [ELEMENT_FRAC_BITS+1:0] i_r22,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic signed [ANGLE_FRAC_BITS+8:0]        o_angle_a,
    output logic signed [ANGLE_FRAC_BITS+7:0]        o_angle_b,
    output logic signed [ANGLE_FRAC_BITS+8:0]        o_angle_c,
    output logic [1:0]                               o_case_code
);
    import rmtea_pkg::*;

    localparam int EW      = ELEMENT_FRAC_BITS + 2;
    localparam int NS      = NORM_W - EW;
    localparam int SIDE_W  = 7 * EW;
    localparam int B_W     = ANGLE_FRAC_BITS + 8;
    localparam logic signed [B_W:0] B_LIM = (B_W+1)'(90) << ANGLE_FRAC_BITS;

    localparam int E00 = 0;
    localparam int E10 = 1;
    localparam int E20 = 2;
    localparam int E01 = 3;
    localparam int E11 = 4;
    localparam int E21 = 5;
    localparam int E22 = 6;

    logic w_en;

    logic                   r_s1_valid;
    logic [SIDE_W-1:0]      r_s1_side;
    logic signed [2*EW-1:0] r_s1_p00;
    logic signed [2*EW-1:0] r_s1_p10;

    logic              r_s2_valid;
    logic [SIDE_W-1:0] r_s2_side;
    logic [SQ_W-1:0]   r_s2_n;
    logic [2*EW-1:0]   w_sum;

    logic              w_sq_valid [SQRT_STEPS+1];
    logic [SQ_W-1:0]   w_sq_n     [SQRT_STEPS+1];
    logic [SQ_W-1:0]   w_sq_r     [SQRT_STEPS+1];
    logic [SIDE_W-1:0] w_sq_side  [SQRT_STEPS+1];

    logic signed [CW-1:0] w_e [7];
    logic signed [CW-1:0] w_h;

    logic      w_cd_valid [CORDIC_STEPS+1];
    t_lane_vec w_cd_lanes [CORDIC_STEPS+1];

    logic [1:0] w_code;

    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    assign w_sum = (2*EW)'(r_s1_p00) + (2*EW)'(r_s1_p10);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_side <= {i_r22, i_r21, i_r11, i_r01, i_r20, i_r10, i_r00};
            r_s1_p00  <= i_r00 * i_r00;
            r_s1_p10  <= i_r10 * i_r10;
            r_s2_side <= r_s1_side;
            r_s2_n    <= SQ_W'(w_sum) << (2 * NS);
        end
    end

    assign w_sq_valid[0] = r_s2_valid;
    assign w_sq_n[0]     = r_s2_n;
    assign w_sq_r[0]     = '0;
    assign w_sq_side[0]  = r_s2_side;

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
        rmtea_sqrt_stage #(
            .STEP   (g),
            .SIDE_W (SIDE_W)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_sq_valid[g]),
            .i_n     (w_sq_n[g]),
            .i_r     (w_sq_r[g]),
            .i_side  (w_sq_side[g]),
            .o_valid (w_sq_valid[g+1]),
            .o_n     (w_sq_n[g+1]),
            .o_r     (w_sq_r[g+1]),
            .o_side  (w_sq_side[g+1])
        );
    end

    always_comb begin
        for (int k = 0; k < 7; k++) begin
            w_e[k] = CW'($signed(w_sq_side[SQRT_STEPS][k*EW +: EW])) <<< (NS + PRE_SCALE);
        end
        w_h = CW'(w_sq_r[SQRT_STEPS][NORM_W-1:0]) <<< PRE_SCALE;
    end

    assign w_cd_valid[0]         = w_sq_valid[SQRT_STEPS];
    assign w_cd_lanes[0][LANE_B]  = prerot(-w_e[E20], w_h);
    assign w_cd_lanes[0][LANE_A]  = prerot(w_e[E10], w_e[E00]);
    assign w_cd_lanes[0][LANE_C]  = prerot(w_e[E21], w_e[E22]);
    assign w_cd_lanes[0][LANE_CS] = prerot(w_e[E01], w_e[E11]);

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        rmtea_cordic_stage #(
            .STEP (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_cd_valid[g]),
            .i_lanes (w_cd_lanes[g]),
            .o_valid (w_cd_valid[g+1]),
            .o_lanes (w_cd_lanes[g+1])
        );
    end

    rmtea_out #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (w_cd_valid[CORDIC_STEPS]),
        .i_lanes     (w_cd_lanes[CORDIC_STEPS]),
        .o_valid     (o_valid),
        .o_angle_a   (o_angle_a),
        .o_angle_b   (o_angle_b),
        .o_angle_c   (o_angle_c),
        .o_case_code (w_code)
    );

    assign o_case_code = w_code;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_sing_a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (w_code == CASE_POS || w_code == CASE_NEG) |-> o_angle_a == '0)
        else $error("angle A not zero in singular case");

    a_b_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((B_W+1)'(o_angle_b) <= B_LIM && (B_W+1)'(o_angle_b) >= -B_LIM))
        else $error("angle B out of range");

    a_pos_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && w_code == CASE_POS |-> !o_angle_b[B_W-1])
        else $error("angle B negative at plus 90 case");

    a_neg_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && w_code == CASE_NEG |-> o_angle_b[B_W-1])
        else $error("angle B not negative at minus 90 case");

endmodule

`default_nettype wire
